>>> design/xts_pkg.sv
//------------------------------------------------------------------------------
// xts_pkg
// Shared types and constants for the XML token scanner.
//------------------------------------------------------------------------------
`default_nettype none
package xts_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SYMBOL = 4'd1,
    PH_STRING = 4'd2,
    PH_STRESC = 4'd3,
    PH_EXCL   = 4'd4,
    PH_CDASH  = 4'd5,
    PH_CBODY  = 4'd6,
    PH_TEXT   = 4'd7,
    PH_ENTITY = 4'd8
  } phase_t;

  localparam logic [4:0] K_LT      = 5'd0;
  localparam logic [4:0] K_GT      = 5'd1;
  localparam logic [4:0] K_QUEST   = 5'd2;
  localparam logic [4:0] K_SLASH   = 5'd3;
  localparam logic [4:0] K_EQ      = 5'd4;
  localparam logic [4:0] K_LPAREN  = 5'd5;
  localparam logic [4:0] K_RPAREN  = 5'd6;
  localparam logic [4:0] K_LBRACK  = 5'd7;
  localparam logic [4:0] K_RBRACK  = 5'd8;
  localparam logic [4:0] K_BAR     = 5'd9;
  localparam logic [4:0] K_STAR    = 5'd10;
  localparam logic [4:0] K_PLUS    = 5'd11;
  localparam logic [4:0] K_COMMA   = 5'd12;
  localparam logic [4:0] K_SEMI    = 5'd13;
  localparam logic [4:0] K_PERCENT = 5'd14;
  localparam logic [4:0] K_HASH    = 5'd15;
  localparam logic [4:0] K_APOS    = 5'd16;
  localparam logic [4:0] K_EXCL    = 5'd17;
  localparam logic [4:0] K_SYMBOL  = 5'd18;
  localparam logic [4:0] K_STRING  = 5'd19;
  localparam logic [4:0] K_COMMENT = 5'd20;
  localparam logic [4:0] K_TEXT    = 5'd21;
  localparam logic [4:0] K_INVALID = 5'd22;
  localparam logic [4:0] K_EOF     = 5'd23;

  localparam logic       CMD_CHAR = 1'b0;
  localparam logic       CMD_EOS  = 1'b1;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] data;
    logic       content;
  } token_t;

  // classified item handed from front to back: up to two tokens
  typedef struct packed {
    logic [1:0]  count;
    token_t      tok0;
    token_t      tok1;
    logic [15:0] line;
  } entry_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c, output logic hit);
    hit = 1'b1;
    unique case (c)
      "<":     return K_LT;
      ">":     return K_GT;
      "?":     return K_QUEST;
      "/":     return K_SLASH;
      "=":     return K_EQ;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "[":     return K_LBRACK;
      "]":     return K_RBRACK;
      "|":     return K_BAR;
      "*":     return K_STAR;
      "+":     return K_PLUS;
      ",":     return K_COMMA;
      ";":     return K_SEMI;
      "%":     return K_PERCENT;
      "#":     return K_HASH;
      8'h27:   return K_APOS;
      default: begin
        hit = 1'b0;
        return K_INVALID;
      end
    endcase
  endfunction

endpackage
`default_nettype wire

>>> design/xts_front.sv
//------------------------------------------------------------------------------
// xts_front
// Scanner state machine: classifies each byte into zero to two tokens.
//------------------------------------------------------------------------------
`default_nettype none
module xts_front import xts_pkg::*; #(
  parameter int ENTITY_MAX_LEN = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       command,
  input  wire logic [7:0] char_in,
  output entry_t          entry
);

  localparam int EW = $clog2(ENTITY_MAX_LEN + 1);

  phase_t          phase_r, phase_nxt;
  logic            tag_r, tag_nxt;
  logic [4:0]      cand_r, cand_nxt;
  logic [EW-1:0]   elen_r, elen_nxt;
  logic [15:0]     line_r, line_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tag_r   <= 1'b0;
      cand_r  <= '0;
      elen_r  <= '0;
      line_r  <= 16'd1;
    end else if (step) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      cand_r  <= cand_nxt;
      elen_r  <= elen_nxt;
      line_r  <= line_nxt;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic       hit, redo, txt;
    logic [4:0] pk;
    logic [4:0] keep;
    token_t     t;
    c = char_in;
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    cand_nxt  = cand_r;
    elen_nxt  = elen_r;
    line_nxt  = line_r;
    entry     = '0;
    redo      = 1'b0;
    txt       = 1'b0;
    hit       = 1'b0;
    pk        = K_INVALID;
    keep      = '0;
    t         = '0;
    if (command == CMD_EOS) begin
      entry.count = 2'd2;
      entry.tok1  = '{K_EOF, 8'd0, 1'b0};
      unique case (phase_r)
        PH_SYMBOL: entry.tok0 = '{K_SYMBOL, 8'd0, 1'b0};
        PH_STRING, PH_STRESC, PH_CDASH, PH_CBODY:
          entry.tok0 = '{K_INVALID, 8'd0, 1'b0};
        PH_EXCL: entry.tok0 = '{K_EXCL, 8'd0, 1'b0};
        default: begin
          entry.count = 2'd1;
          entry.tok0  = '{K_EOF, 8'd0, 1'b0};
        end
      endcase
      phase_nxt = PH_IDLE;
      cand_nxt  = '0;
      elen_nxt  = '0;
    end else begin
      if (c == 8'h0A && line_r != LINE_MAX) line_nxt = line_r + 16'd1;
      unique case (phase_r)
        PH_SYMBOL: begin
          if (is_space(c)) begin
            entry.count = 2'd1; entry.tok0 = '{K_SYMBOL, 8'd0, 1'b0};
            phase_nxt = PH_IDLE;
          end else if (c == "=" || c == "/" || c == ">" || c == "?" || c == "|" ||
                       c == ")" || c == 8'h27 || c == "," || c == ";") begin
            entry.count = 2'd1; entry.tok0 = '{K_SYMBOL, 8'd0, 1'b0};
            phase_nxt = PH_IDLE;
            redo = 1'b1;
          end else if (is_alnum(c) || c == "-" || c == "_") begin
            entry.count = 2'd1; entry.tok0 = '{K_SYMBOL, c, 1'b1};
          end else begin
            entry.count = 2'd1; entry.tok0 = '{K_INVALID, 8'd0, 1'b0};
            phase_nxt = PH_IDLE;
          end
        end
        PH_STRING: begin
          if (c == 8'h5C) phase_nxt = PH_STRESC;
          else if (c == 8'h22) begin
            entry.count = 2'd1; entry.tok0 = '{K_STRING, 8'd0, 1'b0};
            phase_nxt = PH_IDLE;
          end else begin
            entry.count = 2'd1; entry.tok0 = '{K_STRING, c, 1'b1};
          end
        end
        PH_STRESC: begin
          entry.count = 2'd1; entry.tok0 = '{K_STRING, c, 1'b1};
          phase_nxt = PH_STRING;
        end
        PH_EXCL: begin
          if (c == "-") phase_nxt = PH_CDASH;
          else begin
            entry.count = 2'd1; entry.tok0 = '{K_EXCL, 8'd0, 1'b0};
            phase_nxt = PH_IDLE;
            redo = 1'b1;
          end
        end
        PH_CDASH: begin
          if (c == "-") phase_nxt = PH_CBODY;
          else begin
            entry.count = 2'd1; entry.tok0 = '{K_INVALID, 8'd0, 1'b0};
            phase_nxt = PH_IDLE;
          end
        end
        PH_CBODY: begin
          if (c == ">") begin
            entry.count = 2'd1; entry.tok0 = '{K_COMMENT, 8'd0, 1'b0};
            tag_nxt = 1'b0;
            phase_nxt = PH_IDLE;
          end else if (c != 8'h0A) begin
            entry.count = 2'd1; entry.tok0 = '{K_COMMENT, c, 1'b1};
          end
        end
        PH_TEXT: txt = 1'b1;
        PH_ENTITY: begin
          if (c == ";") begin
            priority if (cand_r[0] && elen_r == EW'(2)) begin
              entry.count = 2'd1; entry.tok0 = '{K_TEXT, "<", 1'b1};
            end else if (cand_r[1] && elen_r == EW'(2)) begin
              entry.count = 2'd1; entry.tok0 = '{K_TEXT, ">", 1'b1};
            end else if (cand_r[2] && elen_r == EW'(3)) begin
              entry.count = 2'd1; entry.tok0 = '{K_TEXT, "&", 1'b1};
            end else if (cand_r[3] && elen_r == EW'(2)) begin
              entry.count = 2'd1; entry.tok0 = '{K_TEXT, 8'h0D, 1'b1};
            end else if (cand_r[4] && elen_r == EW'(2)) begin
              entry.count = 2'd1; entry.tok0 = '{K_TEXT, 8'h0A, 1'b1};
            end else begin
              entry.count = 2'd0;
            end
            phase_nxt = PH_TEXT; cand_nxt = '0; elen_nxt = '0;
          end else if (elen_r >= EW'(ENTITY_MAX_LEN)) begin
            phase_nxt = PH_TEXT; cand_nxt = '0; elen_nxt = '0;
            txt = 1'b1;
          end else begin
            keep[0] = (elen_r == EW'(0) && c == "l") || (elen_r == EW'(1) && c == "t");
            keep[1] = (elen_r == EW'(0) && c == "g") || (elen_r == EW'(1) && c == "t");
            keep[2] = (elen_r == EW'(0) && c == "a") || (elen_r == EW'(1) && c == "m") ||
                      (elen_r == EW'(2) && c == "p");
            keep[3] = (elen_r == EW'(0) && c == "l") || (elen_r == EW'(1) && c == "f");
            keep[4] = (elen_r == EW'(0) && c == "n") || (elen_r == EW'(1) && c == "l");
            cand_nxt = cand_r & keep;
            elen_nxt = elen_r + EW'(1);
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          redo = 1'b1;
        end
      endcase

      // idle scan, after a token end where the byte is scanned again
      if (redo && !is_space(c)) begin
        if (!tag_r) begin
          if (c == "<") begin
            t = '{K_LT, 8'd0, 1'b0}; tag_nxt = 1'b1;
          end else begin
            phase_nxt = PH_TEXT;
            txt = 1'b1;
          end
        end else begin
          pk = punct_kind(c, hit);
          if (hit) begin
            t = '{pk, 8'd0, 1'b0};
            if (c == ">") tag_nxt = 1'b0;
          end else if (c == 8'h22) phase_nxt = PH_STRING;
          else if (c == "!") phase_nxt = PH_EXCL;
          else if (is_alnum(c)) begin
            t = '{K_SYMBOL, c, 1'b1}; phase_nxt = PH_SYMBOL;
          end else t = '{K_INVALID, 8'd0, 1'b0};
        end
        if (!txt && (hit || c == "<" || (c != 8'h22 && c != "!"))) begin
          if (entry.count == 2'd0) begin
            entry.count = 2'd1; entry.tok0 = t;
          end else begin
            entry.count = 2'd2; entry.tok1 = t;
          end
        end
      end

      if (txt) begin
        if (c == "<") begin
          entry.count = 2'd2;
          entry.tok0 = '{K_TEXT, 8'd0, 1'b0};
          entry.tok1 = '{K_LT, 8'd0, 1'b0};
          tag_nxt = 1'b1;
          phase_nxt = PH_IDLE;
        end else if (c == "&") begin
          phase_nxt = PH_ENTITY; cand_nxt = 5'h1F; elen_nxt = '0;
        end else begin
          entry.count = 2'd1; entry.tok0 = '{K_TEXT, c, 1'b1};
        end
      end
    end
    entry.line = line_nxt;
  end

endmodule
`default_nettype wire

>>> design/xts_queue.sv
//------------------------------------------------------------------------------
// xts_queue
// Two-entry queue between the scanner front and the output back end.
//------------------------------------------------------------------------------
`default_nettype none
module xts_queue import xts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output logic        empty,
  output entry_t      head
);

  entry_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> design/xts_back.sv
//------------------------------------------------------------------------------
// xts_back
// Output sequencer: emits the tokens of each queued entry, one per transaction.
//------------------------------------------------------------------------------
`default_nettype none
module xts_back import xts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        empty,
  input  wire entry_t      head,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  output logic [4:0]       out_tuser,
  output logic             out_tlast
);

  logic   sel_r;
  token_t t;
  logic   last;

  assign t          = sel_r ? head.tok1 : head.tok0;
  assign last       = sel_r || (head.count == 2'd1);
  assign out_tvalid = !empty;
  assign out_tdata  = {7'd0, head.line, t.content, t.data};
  assign out_tuser  = t.kind;
  assign out_tlast  = last;
  assign pop        = out_tvalid && out_tready && last;

  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else if (out_tvalid && out_tready) sel_r <= !last;
  end

endmodule
`default_nettype wire

>>> design/xml_token_scanner.sv
//------------------------------------------------------------------------------
// xml_token_scanner
// Streaming XML tokenizer, one character per cycle while the queue is not full.
//------------------------------------------------------------------------------
// Accepts one byte (or end-of-stream) per cycle while the queue is not full;
// each byte yields zero, one or two output transactions. The scanner front
// classifies a byte in the cycle it is taken and writes the resulting tokens
// to a two-entry queue; the back end drains one token per cycle unless stalled.
// Sustained rate is one byte per cycle while bytes produce at most one token
// and out_tready is high. Bytes that give no token never enter the queue.
`default_nettype none
module xml_token_scanner import xts_pkg::*; #(
  parameter int ENTITY_MAX_LEN = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_in
  input  wire logic        in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // content_byte, is_content, line_number
  output logic [4:0]       out_tuser,  // token_kind
  output logic             out_tlast   // last_of_run
);

  entry_t ent, head;
  logic   full, empty, pop, step, push;

  assign in_tready = !full;
  assign step      = in_tvalid && in_tready;
  assign push      = step && (ent.count != 2'd0);

  xts_front #(.ENTITY_MAX_LEN(ENTITY_MAX_LEN)) u_front (
    .clk, .rst_n, .step, .command(in_tuser), .char_in(in_tdata), .entry(ent)
  );

  xts_queue u_queue (
    .clk, .rst_n, .push, .push_data(ent), .full, .pop, .empty, .head
  );

  xts_back u_back (
    .clk, .rst_n, .empty, .head, .pop, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .out_tlast
  );

  a_eos_out: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_tuser == CMD_EOS) |-> push)
    else $error("end of stream produced no token");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_content_not_last_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == K_EOF) |-> (out_tlast && !out_tdata[8]))
    else $error("eof token malformed");

endmodule
`default_nettype wire
